@@ rtl/soe_pkg.sv @@
// Shared types and codes of the set operation engine.
`default_nettype none

package soe_pkg;

    localparam int unsigned DATA_W = 32;

    // command codes
    localparam logic [1:0] CMD_CLEAR    = 2'd0;
    localparam logic [1:0] CMD_APPEND_A = 2'd1;
    localparam logic [1:0] CMD_APPEND_B = 2'd2;
    localparam logic [1:0] CMD_RUN      = 2'd3;

    // operation codes
    localparam logic [3:0] OP_UNION     = 4'd0;
    localparam logic [3:0] OP_INTERSECT = 4'd1;
    localparam logic [3:0] OP_A_MINUS_B = 4'd2;
    localparam logic [3:0] OP_B_MINUS_A = 4'd3;
    localparam logic [3:0] OP_SYM_DIFF  = 4'd4;
    localparam logic [3:0] OP_NOT_A     = 4'd5;
    localparam logic [3:0] OP_NOT_B     = 4'd6;
    localparam logic [3:0] OP_A_X_B     = 4'd7;
    localparam logic [3:0] OP_B_X_A     = 4'd8;

    // kind of scan the sequencer is stepping through
    typedef enum logic [3:0] {
        W_UNION_A,
        W_UNION_B,
        W_INTERSECT,
        W_A_MINUS_B,
        W_B_MINUS_A,
        W_NOT_A,
        W_NOT_B,
        W_A_X_B,
        W_B_X_A
    } t_walk;

    typedef struct packed {
        logic signed [DATA_W-1:0] first_value;
        logic signed [DATA_W-1:0] second_value;
        logic                     is_empty;
        logic                     last;
    } t_result;

    typedef struct packed {
        logic  clear;
        logic  load_a;
        logic  load_b;
        logic  step;
        logic  flush;
        t_walk walk;
    } t_dp_cmd;

    typedef struct packed {
        logic step_ok;
        logic flush_ok;
    } t_dp_stat;

endpackage

`default_nettype wire

@@ rtl/soe_if.sv @@
// Channel interfaces: command input and result output.
`default_nettype none

interface soe_in_if;
    import soe_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [1:0]               command;
    logic signed [DATA_W-1:0] value;
    logic [3:0]               operation;
    modport source (output valid, command, value, operation, input ready);
    modport sink   (input valid, command, value, operation, output ready);
endinterface

interface soe_out_if;
    import soe_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] first_value;
    logic signed [DATA_W-1:0] second_value;
    logic                     is_empty;
    logic                     last;
    modport source (output valid, first_value, second_value, is_empty, last, input ready);
    modport sink   (input valid, first_value, second_value, is_empty, last, output ready);
endinterface

`default_nettype wire

@@ rtl/set_operation_engine_top.sv @@
// Top level of the set operation engine: controller, datapath, channel ports.
//
// Input channel i_in carries one command beat: clear both sets, append value to
// set A, append value to set B, or run an operation. Output channel o_out carries
// result beats; the final beat of a run has last set, and an empty result is a
// single beat with is_empty and last set and zero values.
// Appends to a full set are dropped. A run occupies the input side: the run
// beat is accepted, the sequencer takes one step per scanned entry or pair, and
// a close-out step ends it. Union scans count_a + count_b entries, differences
// the count of the outer set, symmetric difference count_a + count_b, and
// intersection and products count_a * count_b pairs; complements scan
// UNIVERSE_TOP values, and a scan phase over an empty set takes no step. The
// single scan sequencer in the controller walks all of these scans.
// Results lag the scan by one held beat so that last is known.
// When the receiver stalls, the held beat and the output register fill and
// the scan waits; nothing is lost. Reset empties both sets and drops any beat
// in flight; the stores need no clearing pass.
`default_nettype none

module set_operation_engine_top #(
    parameter int MAX_ELEMENTS = 8,
    parameter int UNIVERSE_TOP = 50
) (
    input wire          i_clk,
    input wire          i_rst_n,
    soe_in_if.sink      i_in,
    soe_out_if.source   o_out
);
    import soe_pkg::*;

    localparam int LMAX = (MAX_ELEMENTS > UNIVERSE_TOP) ? MAX_ELEMENTS : UNIVERSE_TOP;
    localparam int LW   = $clog2(LMAX + 1);
    localparam int CW   = $clog2(MAX_ELEMENTS + 1);

    t_dp_cmd       w_cmd;
    t_dp_stat      w_stat;
    logic [LW-1:0] w_idx_i;
    logic [LW-1:0] w_idx_j;
    logic [CW-1:0] w_count_a;
    logic [CW-1:0] w_count_b;
    logic          w_in_ready;
    logic          w_out_valid;
    t_result       w_out;

    // sequencer: decodes beats and walks indices
    soe_ctrl #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .UNIVERSE_TOP (UNIVERSE_TOP)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (w_in_ready),
        .i_command   (i_in.command),
        .i_operation (i_in.operation),
        .i_count_a   (w_count_a),
        .i_count_b   (w_count_b),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_idx_i     (w_idx_i),
        .o_idx_j     (w_idx_j)
    );

    // stores, compares and result registers
    soe_dp #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .UNIVERSE_TOP (UNIVERSE_TOP)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_idx_i     (w_idx_i),
        .i_idx_j     (w_idx_j),
        .i_value     (i_in.value),
        .o_stat      (w_stat),
        .o_count_a   (w_count_a),
        .o_count_b   (w_count_b),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_out.ready),
        .o_out       (w_out)
    );

    assign i_in.ready         = w_in_ready;
    assign o_out.valid        = w_out_valid;
    assign o_out.first_value  = w_out.first_value;
    assign o_out.second_value = w_out.second_value;
    assign o_out.is_empty     = w_out.is_empty;
    assign o_out.last         = w_out.last;

    // nothing offered right after reset
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_out.valid)
        else $error("output valid after reset");

    // empty beat closes the run and carries zero values
    a_empty_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.is_empty) |->
            (o_out.last && (o_out.first_value == '0) && (o_out.second_value == '0)))
        else $error("malformed empty beat");

    // set sizes stay within capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_count_a <= CW'(MAX_ELEMENTS)) && (w_count_b <= CW'(MAX_ELEMENTS)))
        else $error("set count beyond capacity");

    // scan steps only with room for the held beat, never together with close-out
    a_step_gate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.step |-> (w_stat.step_ok && !w_cmd.flush))
        else $error("scan step without room");

endmodule

`default_nettype wire

@@ rtl/soe_dp.sv @@
// Datapath: set stores, membership compares, pending and output result registers.
`default_nettype none

module soe_dp #(
    parameter int MAX_ELEMENTS = 8,
    parameter int UNIVERSE_TOP = 50,
    localparam int LMAX = (MAX_ELEMENTS > UNIVERSE_TOP) ? MAX_ELEMENTS : UNIVERSE_TOP,
    localparam int LW   = $clog2(LMAX + 1),
    localparam int CW   = $clog2(MAX_ELEMENTS + 1),
    localparam int AW   = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  soe_pkg::t_dp_cmd                  i_cmd,
    input  wire [LW-1:0]                      i_idx_i,
    input  wire [LW-1:0]                      i_idx_j,
    input  wire signed [soe_pkg::DATA_W-1:0]  i_value,
    output soe_pkg::t_dp_stat                 o_stat,
    output logic [CW-1:0]                     o_count_a,
    output logic [CW-1:0]                     o_count_b,
    output logic                              o_out_valid,
    input  wire                               i_out_ready,
    output soe_pkg::t_result                  o_out
);
    import soe_pkg::*;

    logic [DATA_W-1:0]       r_a [MAX_ELEMENTS];
    logic [DATA_W-1:0]       r_b [MAX_ELEMENTS];
    logic [CW-1:0]           r_count_a;
    logic [CW-1:0]           r_count_b;
    logic [MAX_ELEMENTS-1:0] r_marks;
    logic                    r_pend_valid;
    t_result                 r_pend;
    logic                    r_out_valid;
    t_result                 r_out;

    logic              w_outer_a;
    logic              w_is_not;
    logic              w_is_prod;
    logic [AW-1:0]     w_a_idx;
    logic [AW-1:0]     w_b_idx;
    logic [DATA_W-1:0] w_a_rd;
    logic [DATA_W-1:0] w_b_rd;
    logic [DATA_W-1:0] w_x;
    logic [DATA_W-1:0] w_y;
    logic              w_in_a;
    logic              w_in_b;
    logic              w_dup_b;
    logic              w_hit;
    logic              w_slot_free;
    logic              w_do_load_a;
    logic              w_do_load_b;
    t_result           w_new;
    t_result           w_close;

    assign w_outer_a = (i_cmd.walk inside {W_UNION_A, W_INTERSECT, W_A_MINUS_B, W_A_X_B});
    assign w_is_not  = (i_cmd.walk == W_NOT_A) || (i_cmd.walk == W_NOT_B);
    assign w_is_prod = (i_cmd.walk == W_A_X_B) || (i_cmd.walk == W_B_X_A);

    // each store read at one address: outer index goes to the outer set
    assign w_a_idx = w_outer_a ? i_idx_i[AW-1:0] : i_idx_j[AW-1:0];
    assign w_b_idx = w_outer_a ? i_idx_j[AW-1:0] : i_idx_i[AW-1:0];
    assign w_a_rd  = r_a[w_a_idx];
    assign w_b_rd  = r_b[w_b_idx];

    // complement probes walk 1..UNIVERSE_TOP
    assign w_x = w_is_not ? (DATA_W'(i_idx_i) + DATA_W'(1)) : (w_outer_a ? w_a_rd : w_b_rd);
    assign w_y = w_outer_a ? w_b_rd : w_a_rd;

    always_comb begin
        w_in_a  = 1'b0;
        w_in_b  = 1'b0;
        w_dup_b = 1'b0;
        for (int k = 0; k < MAX_ELEMENTS; k++) begin
            if ((CW'(k) < r_count_a) && (r_a[k] == w_x)) w_in_a = 1'b1;
            if ((CW'(k) < r_count_b) && (r_b[k] == w_x)) w_in_b = 1'b1;
            // earlier B entry already taken by this union
            if ((LW'(k) < i_idx_i) && r_marks[k] && (r_b[k] == w_x)) w_dup_b = 1'b1;
        end
    end

    always_comb begin
        case (i_cmd.walk) inside
            W_UNION_A, W_A_X_B, W_B_X_A: w_hit = 1'b1;
            W_UNION_B:                   w_hit = !w_in_a && !w_dup_b;
            W_INTERSECT:                 w_hit = (w_x == w_y);
            W_A_MINUS_B, W_NOT_B:        w_hit = !w_in_b;
            W_B_MINUS_A, W_NOT_A:        w_hit = !w_in_a;
            default:                     w_hit = 1'b0;
        endcase
    end

    always_comb begin
        w_new.first_value  = w_x;
        w_new.second_value = w_is_prod ? w_y : '0;
        w_new.is_empty     = 1'b0;
        w_new.last         = 1'b0;
    end

    // closing beat: held beat marked last, or the empty beat
    always_comb begin
        if (r_pend_valid) begin
            w_close      = r_pend;
            w_close.last = 1'b1;
        end else begin
            w_close          = '0;
            w_close.is_empty = 1'b1;
            w_close.last     = 1'b1;
        end
    end

    // a new hit pushes the held one out, so the held one needs the slot
    assign w_slot_free     = !r_out_valid || i_out_ready;
    assign o_stat.step_ok  = !r_pend_valid || w_slot_free;
    assign o_stat.flush_ok = w_slot_free;

    assign w_do_load_a = i_cmd.load_a && (r_count_a < CW'(MAX_ELEMENTS));
    assign w_do_load_b = i_cmd.load_b && (r_count_b < CW'(MAX_ELEMENTS));

    always_ff @(posedge i_clk) begin
        if (w_do_load_a) r_a[r_count_a[AW-1:0]] <= i_value;
        if (w_do_load_b) r_b[r_count_b[AW-1:0]] <= i_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_a    <= '0;
            r_count_b    <= '0;
            r_marks      <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_count_a <= '0;
                r_count_b <= '0;
                r_marks   <= '0;
            end
            if (w_do_load_a) r_count_a <= r_count_a + CW'(1);
            if (w_do_load_b) r_count_b <= r_count_b + CW'(1);
            if (i_cmd.step && (i_cmd.walk == W_UNION_B)) r_marks[w_b_idx] <= w_hit;
            if (i_cmd.flush) begin
                r_out_valid  <= 1'b1;
                r_pend_valid <= 1'b0;
            end else if (i_cmd.step && w_hit) begin
                r_out_valid  <= r_pend_valid || (r_out_valid && !i_out_ready);
                r_pend_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.flush) begin
            r_out <= w_close;
        end else if (i_cmd.step && w_hit) begin
            if (r_pend_valid) r_out <= r_pend;
            r_pend <= w_new;
        end
    end

    assign o_count_a   = r_count_a;
    assign o_count_b   = r_count_b;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

@@ rtl/soe_ctrl.sv @@
// Controller: command decode and the scan sequencer over the stored sets.
`default_nettype none

module soe_ctrl #(
    parameter int MAX_ELEMENTS = 8,
    parameter int UNIVERSE_TOP = 50,
    localparam int LMAX = (MAX_ELEMENTS > UNIVERSE_TOP) ? MAX_ELEMENTS : UNIVERSE_TOP,
    localparam int LW   = $clog2(LMAX + 1),
    localparam int CW   = $clog2(MAX_ELEMENTS + 1)
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  wire [1:0]          i_command,
    input  wire [3:0]          i_operation,
    input  wire [CW-1:0]       i_count_a,
    input  wire [CW-1:0]       i_count_b,
    input  soe_pkg::t_dp_stat  i_stat,
    output soe_pkg::t_dp_cmd   o_cmd,
    output logic [LW-1:0]      o_idx_i,
    output logic [LW-1:0]      o_idx_j
);
    import soe_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_WALK1 = 4'b0010,
        S_WALK2 = 4'b0100,
        S_FLUSH = 4'b1000
    } t_state;

    t_state      r_state, n_state;
    logic [3:0]  r_op, n_op;
    logic [LW-1:0] r_i, n_i;
    logic [LW-1:0] r_j, n_j;

    t_walk         w_walk;
    logic          w_two_phase;
    logic [LW-1:0] w_outer;
    logic [LW-1:0] w_inner;
    logic          w_empty_loop;
    logic          w_i_end;
    logic          w_j_end;
    logic          w_accept;
    t_state        w_after;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        unique case (r_op)
            OP_UNION:     w_walk = (r_state == S_WALK2) ? W_UNION_B : W_UNION_A;
            OP_INTERSECT: w_walk = W_INTERSECT;
            OP_A_MINUS_B: w_walk = W_A_MINUS_B;
            OP_B_MINUS_A: w_walk = W_B_MINUS_A;
            OP_SYM_DIFF:  w_walk = (r_state == S_WALK2) ? W_B_MINUS_A : W_A_MINUS_B;
            OP_NOT_A:     w_walk = W_NOT_A;
            OP_NOT_B:     w_walk = W_NOT_B;
            OP_A_X_B:     w_walk = W_A_X_B;
            OP_B_X_A:     w_walk = W_B_X_A;
            default:      w_walk = W_UNION_A;
        endcase
    end

    assign w_two_phase = (r_op == OP_UNION) || (r_op == OP_SYM_DIFF);

    always_comb begin
        case (w_walk) inside
            W_UNION_A, W_INTERSECT, W_A_MINUS_B, W_A_X_B: w_outer = LW'(i_count_a);
            W_UNION_B, W_B_MINUS_A, W_B_X_A:              w_outer = LW'(i_count_b);
            default:                                      w_outer = LW'(UNIVERSE_TOP);
        endcase
        case (w_walk) inside
            W_INTERSECT, W_A_X_B: w_inner = LW'(i_count_b);
            W_B_X_A:              w_inner = LW'(i_count_a);
            default:              w_inner = LW'(1);
        endcase
    end

    assign w_empty_loop = (w_outer == '0) || (w_inner == '0);
    assign w_i_end      = (r_i == (w_outer - LW'(1)));
    assign w_j_end      = (r_j == (w_inner - LW'(1)));
    assign w_after      = ((r_state == S_WALK1) && w_two_phase) ? S_WALK2 : S_FLUSH;

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_i        = r_i;
        n_j        = r_j;
        o_cmd      = '0;
        o_cmd.walk = w_walk;
        unique case (r_state) inside
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_command)
                        CMD_CLEAR:    o_cmd.clear  = 1'b1;
                        CMD_APPEND_A: o_cmd.load_a = 1'b1;
                        CMD_APPEND_B: o_cmd.load_b = 1'b1;
                        CMD_RUN: begin
                            n_op    = i_operation;
                            n_i     = '0;
                            n_j     = '0;
                            n_state = (i_operation <= OP_B_X_A) ? S_WALK1 : S_FLUSH;
                        end
                        default: ;
                    endcase
                end
            end
            S_WALK1, S_WALK2: begin
                if (w_empty_loop) begin
                    n_state = w_after;
                end else if (i_stat.step_ok) begin
                    o_cmd.step = 1'b1;
                    if (w_j_end) begin
                        n_j = '0;
                        if (w_i_end) begin
                            n_i     = '0;
                            n_state = w_after;
                        end else begin
                            n_i = r_i + LW'(1);
                        end
                    end else begin
                        n_j = r_j + LW'(1);
                    end
                end
            end
            S_FLUSH: begin
                if (i_stat.flush_ok) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op;
    end

    assign o_idx_i = r_i;
    assign o_idx_j = r_j;

endmodule

`default_nettype wire

@@ test/soe_result_checker.sv @@
`timescale 1ns / 100ps
// Result scoreboard for the set operation engine: predicts each run's beats and compares them.
module soe_result_checker #(
    parameter int MAX_ELEMENTS = 8,
    parameter int UNIVERSE_TOP = 50
) (
    input  logic i_clk,
    input  logic i_rst_n,
    soe_in_if    i_cmd,
    soe_out_if   i_res,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_beats_checked
);
    import soe_pkg::*;

    localparam int REPORT_LIMIT = 10;
    localparam int MAX_RESULTS  = 64;

    logic signed [DATA_W-1:0] store_a [MAX_ELEMENTS];
    logic signed [DATA_W-1:0] store_b [MAX_ELEMENTS];
    int fill_a = 0;
    int fill_b = 0;

    t_result expected_beats [$];
    t_result run_beats [$];
    int fail_count = 0;
    int beats_checked = 0;

    function automatic int fill_of(input bit of_b);
        return of_b ? fill_b : fill_a;
    endfunction

    function automatic logic signed [DATA_W-1:0] element(input bit of_b, input int idx);
        return of_b ? store_b[idx] : store_a[idx];
    endfunction

    function automatic bit member_of(input bit of_b, input logic signed [DATA_W-1:0] v);
        for (int i = 0; i < fill_of(of_b); i++) begin
            if (element(of_b, i) == v) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void add_beat(input logic signed [DATA_W-1:0] first,
                                     input logic signed [DATA_W-1:0] second);
        t_result beat;
        beat = '0;
        beat.first_value  = first;
        beat.second_value = second;
        if (run_beats.size() < MAX_RESULTS) run_beats.push_back(beat);
    endfunction

    // elements of one set that are absent from the other, in stored order
    function automatic void add_difference(input bit from_b);
        for (int i = 0; i < fill_of(from_b); i++) begin
            if (!member_of(!from_b, element(from_b, i))) add_beat(element(from_b, i), '0);
        end
    endfunction

    function automatic void add_complement(input bit of_b);
        for (int v = 1; v <= UNIVERSE_TOP && v <= MAX_RESULTS; v++) begin
            if (!member_of(of_b, v)) add_beat(v, '0);
        end
    endfunction

    function automatic void add_product(input bit rows_b);
        for (int i = 0; i < fill_of(rows_b); i++) begin
            for (int j = 0; j < fill_of(!rows_b); j++) begin
                add_beat(element(rows_b, i), element(!rows_b, j));
            end
        end
    endfunction

    function automatic void predict_run(input logic [3:0] op);
        bit      taken [MAX_ELEMENTS];
        bit      dup;
        t_result closing;
        run_beats.delete();
        case (op)
            OP_UNION: begin
                for (int i = 0; i < fill_a; i++) add_beat(store_a[i], '0);
                // B elements already in A, or equal to a B element taken earlier, are skipped
                for (int j = 0; j < fill_b; j++) begin
                    dup = member_of(1'b0, store_b[j]);
                    for (int k = 0; k < j && !dup; k++) begin
                        if (taken[k] && store_b[k] == store_b[j]) dup = 1'b1;
                    end
                    taken[j] = !dup;
                    if (!dup) add_beat(store_b[j], '0);
                end
            end
            OP_INTERSECT: begin
                for (int i = 0; i < fill_a; i++) begin
                    for (int j = 0; j < fill_b; j++) begin
                        if (store_a[i] == store_b[j]) add_beat(store_a[i], '0);
                    end
                end
            end
            OP_A_MINUS_B: add_difference(1'b0);
            OP_B_MINUS_A: add_difference(1'b1);
            OP_SYM_DIFF: begin
                add_difference(1'b0);
                add_difference(1'b1);
            end
            OP_NOT_A: add_complement(1'b0);
            OP_NOT_B: add_complement(1'b1);
            OP_A_X_B: add_product(1'b0);
            OP_B_X_A: add_product(1'b1);
            default: ;
        endcase
        if (run_beats.size() == 0) begin
            closing = '0;
            closing.is_empty = 1'b1;
            run_beats.push_back(closing);
        end
        closing = run_beats.pop_back();
        closing.last = 1'b1;
        run_beats.push_back(closing);
        foreach (run_beats[n]) expected_beats.push_back(run_beats[n]);
    endfunction

    function automatic void apply_command(input logic [1:0] cmd,
                                          input logic signed [DATA_W-1:0] val,
                                          input logic [3:0] op);
        case (cmd)
            CMD_CLEAR: begin
                fill_a = 0;
                fill_b = 0;
            end
            CMD_APPEND_A: begin
                if (fill_a < MAX_ELEMENTS) begin
                    store_a[fill_a] = val;
                    fill_a++;
                end
            end
            CMD_APPEND_B: begin
                if (fill_b < MAX_ELEMENTS) begin
                    store_b[fill_b] = val;
                    fill_b++;
                end
            end
            default: predict_run(op);
        endcase
    endfunction

    function automatic void compare_beat(input t_result got);
        t_result want;
        beats_checked++;
        if (expected_beats.size() == 0) begin
            if (fail_count < REPORT_LIMIT)
                $display("unexpected result beat: first=%0d second=%0d empty=%0b last=%0b",
                         got.first_value, got.second_value, got.is_empty, got.last);
            fail_count++;
            return;
        end
        want = expected_beats.pop_front();
        if (got.first_value !== want.first_value || got.second_value !== want.second_value ||
            got.is_empty !== want.is_empty || got.last !== want.last) begin
            if (fail_count < REPORT_LIMIT)
                $display("beat %0d mismatch: want %0d,%0d empty=%0b last=%0b got %0d,%0d empty=%0b last=%0b",
                         beats_checked, want.first_value, want.second_value, want.is_empty,
                         want.last, got.first_value, got.second_value, got.is_empty, got.last);
            fail_count++;
        end
    endfunction

    // output beats first: nothing accepted on this edge can already have a result
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fill_a = 0;
            fill_b = 0;
            expected_beats.delete();
        end else begin
            if (i_res.valid && i_res.ready)
                compare_beat('{first_value: i_res.first_value, second_value: i_res.second_value,
                               is_empty: i_res.is_empty, last: i_res.last});
            if (i_cmd.valid && i_cmd.ready)
                apply_command(i_cmd.command, i_cmd.value, i_cmd.operation);
        end
        o_pending <= expected_beats.size();
    end

    assign o_fail_count    = fail_count;
    assign o_beats_checked = beats_checked;

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// Top of the set operation engine bench: clock, reset, command stimulus, output stalls, verdict.
module testbench;
    import soe_pkg::*;

    localparam int MAX_ELEMENTS     = 8;
    localparam int UNIVERSE_TOP     = 50;
    localparam int TOTAL_BEATS      = 330;   // command beats, directed part included
    localparam int MAX_GAP          = 18;    // longest per-beat idle on either side
    localparam int HOLD_OFF_CYCLES  = 300;   // long receiver stall that backs up the engine
    localparam int HOLD_PERIOD      = 700;   // result beats between long stalls
    localparam int HOLD_FIRST_AT    = 40;
    localparam int DRAIN_CYCLES     = 64;    // watch for stray beats after the last predicted one
    localparam int WATCHDOG_LIMIT   = 3000;  // cycles with no beat on either channel

    // operation code past the defined range, used to hit the empty-result path
    localparam logic [3:0] OP_CODE_TOP = 4'hF;

    logic clk;
    logic rst_n;

    soe_in_if  in_ch ();
    soe_out_if out_ch ();

    int fail_count;
    int pending;
    int beats_checked;

    int beats_sent  = 0;
    int runs_sent   = 0;
    int send_quiet  = 0;
    int idle_cycles = 0;

    set_operation_engine_top #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .UNIVERSE_TOP (UNIVERSE_TOP)
    ) uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    soe_result_checker #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .UNIVERSE_TOP (UNIVERSE_TOP)
    ) result_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cmd           (in_ch),
        .i_res           (out_ch),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_beats_checked (beats_checked)
    );

    // 4 ns clock, low phase first so there is no rising edge at time zero
    always begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Per-beat wait on either side. Now and then a quiet stretch of
    // back-to-back beats is started so both busy and gappy traffic occur.
    function automatic int draw_wait(inout int quiet_left);
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 11) == 0) quiet_left = $urandom_range(8, 40);
        return $urandom_range(0, MAX_GAP);
    endfunction

    // Element values: mostly small so sets overlap and repeat, some inside
    // the complement universe, some at the 32-bit extremes, some anywhere.
    function automatic logic signed [DATA_W-1:0] pick_element();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom_range(1, 10);
            4, 5:       return $urandom_range(1, UNIVERSE_TOP);
            6: begin
                case ($urandom_range(0, 4))
                    0:       return 32'sh7FFF_FFFF;
                    1:       return 32'sh8000_0000;
                    2:       return '0;
                    3:       return -1;
                    default: return UNIVERSE_TOP + 1;
                endcase
            end
            default:    return $urandom();
        endcase
    endfunction

    // Mostly moderate sets; sometimes empty, sometimes filled to or past capacity.
    function automatic int pick_fill();
        case ($urandom_range(0, 7))
            0:       return 0;
            7:       return $urandom_range(MAX_ELEMENTS, MAX_ELEMENTS + 2);
            default: return $urandom_range(1, 5);
        endcase
    endfunction

    function automatic logic [3:0] pick_operation();
        if ($urandom_range(0, 9) == 0) return 4'($urandom_range(OP_B_X_A + 1, OP_CODE_TOP));
        return 4'($urandom_range(OP_UNION, OP_B_X_A));
    endfunction

    // One command beat: optional idle gap, then hold valid until ready.
    // The field that a command does not use carries random junk.
    task automatic send_beat(input logic [1:0] cmd, input logic signed [DATA_W-1:0] val,
                             input logic [3:0] op);
        int gap;
        gap = draw_wait(send_quiet);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.command   <= cmd;
        in_ch.value     <= val;
        in_ch.operation <= op;
        do @(posedge clk); while (!in_ch.ready);
        beats_sent++;
        if (cmd == CMD_RUN) runs_sent++;
    endtask

    // Receiver: random stall before each result beat, plus a long hold-off
    // now and then. The engine keeps scanning into its held beat and output
    // register, then stops taking commands while the sender keeps offering.
    initial begin
        int stall;
        int quiet;
        int taken;
        quiet = 0;
        taken = 0;
        out_ch.ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            stall = draw_wait(quiet);
            if (taken % HOLD_PERIOD == HOLD_FIRST_AT) stall = HOLD_OFF_CYCLES;
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid);
            taken++;
        end
    end

    // Watchdog: a missing result or a hung handshake stops all beats.
    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles, %0d results outstanding",
                     WATCHDOG_LIMIT, pending);
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int want_a;
        int want_b;
        int runs;
        int shape;

        rst_n           <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.command   <= CMD_CLEAR;
        in_ch.value     <= '0;
        in_ch.operation <= OP_UNION;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part.
        // Clear, then complement of an empty A: every value 1..UNIVERSE_TOP comes out.
        // This long run also meets the first long receiver hold-off.
        send_beat(CMD_CLEAR, 32'sh5A5A_A5A5, OP_CODE_TOP);
        send_beat(CMD_RUN, '0, OP_NOT_A);

        // A gets both 32-bit extremes, zero, -1, a repeated value and both ends
        // of the universe; the ninth append is past capacity and must be dropped.
        send_beat(CMD_APPEND_A, 32'sh7FFF_FFFF, OP_B_X_A);
        send_beat(CMD_APPEND_A, 32'sh8000_0000, OP_UNION);
        send_beat(CMD_APPEND_A, '0, OP_NOT_B);
        send_beat(CMD_APPEND_A, -1, OP_INTERSECT);
        send_beat(CMD_APPEND_A, 3, OP_SYM_DIFF);
        send_beat(CMD_APPEND_A, 3, OP_A_MINUS_B);
        send_beat(CMD_APPEND_A, UNIVERSE_TOP, OP_B_MINUS_A);
        send_beat(CMD_APPEND_A, 1, OP_A_X_B);
        send_beat(CMD_APPEND_A, 9, OP_NOT_A);

        // B: one value shared with A, a value repeated inside B only, and the
        // value that A holds twice, so union and intersection see duplicates.
        send_beat(CMD_APPEND_B, -1, OP_CODE_TOP);
        send_beat(CMD_APPEND_B, 7, OP_UNION);
        send_beat(CMD_APPEND_B, 7, OP_UNION);
        send_beat(CMD_APPEND_B, 3, OP_UNION);

        // Every defined operation on these sets, then an undefined code.
        for (int op = int'(OP_UNION); op <= OP_B_X_A; op++)
            send_beat(CMD_RUN, $urandom(), 4'(op));
        send_beat(CMD_RUN, $urandom(), OP_CODE_TOP);

        // Random part: mostly clear / load / run sequences with random content.
        // Some sequences skip the clear and build on stale sets, some load and
        // never run; the interleaving of A and B appends is random too.
        while (beats_sent < TOTAL_BEATS) begin
            shape = $urandom_range(0, 9);
            if (shape != 0) send_beat(CMD_CLEAR, $urandom(), 4'($urandom_range(0, OP_CODE_TOP)));
            want_a = pick_fill();
            want_b = pick_fill();
            while (want_a > 0 || want_b > 0) begin
                if (want_b == 0 || (want_a > 0 && $urandom_range(0, 1) == 0)) begin
                    send_beat(CMD_APPEND_A, pick_element(),
                              4'($urandom_range(0, OP_CODE_TOP)));
                    want_a--;
                end else begin
                    send_beat(CMD_APPEND_B, pick_element(),
                              4'($urandom_range(0, OP_CODE_TOP)));
                    want_b--;
                end
            end
            if (shape != 1) begin
                runs = $urandom_range(1, 3);
                repeat (runs) send_beat(CMD_RUN, $urandom(), pick_operation());
            end
        end
        in_ch.valid <= 1'b0;

        // Let every predicted result arrive, then watch a little longer for strays.
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d command beats with %0d runs and %0d result beats compared",
                 beats_sent, runs_sent, beats_checked);
        $display("all nine operations, undefined codes, empty and overfilled sets, long stalls");
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/soe_pkg.sv
rtl/soe_if.sv
rtl/soe_dp.sv
rtl/soe_ctrl.sv
rtl/set_operation_engine_top.sv
test/soe_result_checker.sv
test/testbench.sv
